>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define GDR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define GDR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/gdr_pkg.sv
// ----------------------------------------------------------------------------
// gdr_pkg
// Constants, types and command/status bundles of the grid DDA wall caster.
// ----------------------------------------------------------------------------
`default_nettype none

package gdr_pkg;

  localparam int MAP_SIZE  = 32;
  localparam int TEX_SIZE  = 64;
  localparam int MAX_STEPS = 64;

  localparam int MAP_BITS  = $clog2(MAP_SIZE);
  localparam int MAP_CELLS = MAP_SIZE * MAP_SIZE;
  localparam int ADDR_W    = $clog2(MAP_CELLS);
  localparam int M_W       = ((MAP_BITS > 5) ? MAP_BITS : 5) + 2;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);

  localparam int SCR_W     = 12;
  localparam int POS_W     = 21;
  localparam int DIR_W     = 18;
  localparam int PLANE_W   = 19;
  localparam int COL_W     = 11;
  localparam int CELL_W    = 5;
  localparam int CODE_W    = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 21;

  localparam int CAM_W     = 30;
  localparam int R_W       = 33;
  localparam int DELTA_W   = 41;
  localparam int SD_W      = 48;
  localparam int NUM_W     = 24;
  localparam int PERP_W    = 24;
  localparam int LH_W      = 16;
  localparam int FRAC_W    = 16;
  localparam int TC_W      = 9;

  localparam int DIVN_W    = 40;
  localparam int DIVD_W    = 32;
  localparam int DIV_ITER  = DIVN_W / 2;
  localparam int ITER_W    = $clog2(DIV_ITER + 1);

  localparam int MUL_A_W   = 34;
  localparam int MUL_B_W   = 26;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;

  localparam logic [SCR_W-1:0]   RST_WIDTH   = 12'd640;
  localparam logic [SCR_W-1:0]   RST_HEIGHT  = 12'd480;
  localparam logic [POS_W-1:0]   RST_POS_X   = 21'd1441792;
  localparam logic [POS_W-1:0]   RST_POS_Y   = 21'd786432;
  localparam logic [DIR_W-1:0]   RST_DIR_X   = 18'h30000;
  localparam logic [DIR_W-1:0]   RST_DIR_Y   = 18'h00000;
  localparam logic [PLANE_W-1:0] RST_PLANE_X = 19'd0;
  localparam logic [PLANE_W-1:0] RST_PLANE_Y = 19'd43254;

  localparam logic [PERP_W-1:0]  PERP_MAX    = '1;
  localparam logic [LH_W-1:0]    LH_MAX      = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 3'd0,
    CFG_SCREEN_HEIGHT = 3'd1,
    CFG_VIEW_POS_X    = 3'd2,
    CFG_VIEW_POS_Y    = 3'd3,
    CFG_VIEW_DIR_X    = 3'd4,
    CFG_VIEW_DIR_Y    = 3'd5,
    CFG_CAM_PLANE_X   = 3'd6,
    CFG_CAM_PLANE_Y   = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    DIV_CAM  = 3'd0,
    DIV_DX   = 3'd1,
    DIV_DY   = 3'd2,
    DIV_PERP = 3'd3,
    DIV_LH   = 3'd4
  } div_sel_e;

  typedef enum logic [2:0] {
    MUL_RX   = 3'd0,
    MUL_RY   = 3'd1,
    MUL_SDX  = 3'd2,
    MUL_SDY  = 3'd3,
    MUL_FRAC = 3'd4
  } mul_sel_e;

  typedef struct packed {
    logic [SCR_W-1:0]   screen_width;
    logic [SCR_W-1:0]   screen_height;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [DIR_W-1:0]   dir_x;
    logic [DIR_W-1:0]   dir_y;
    logic [PLANE_W-1:0] plane_x;
    logic [PLANE_W-1:0] plane_y;
  } cfg_t;

  typedef struct packed {
    logic     cast_start;
    logic     map_write;
    logic     div_start;
    logic     div_take;
    div_sel_e div_sel;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     rx_load;
    logic     ry_load;
    logic     sdx_load;
    logic     dda_init;
    logic     step;
    logic     look;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic steps_done;
    logic next_oob;
    logic cell_hit;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

>>> src/gdr_div.sv
// ----------------------------------------------------------------------------
// gdr_div
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gdr_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [gdr_pkg::DIVN_W-1:0] dividend_i,
  input  wire logic [gdr_pkg::DIVD_W-1:0] divisor_i,
  output logic                            done_o,
  output logic      [gdr_pkg::DIVN_W-1:0] quotient_o
);

  logic [gdr_pkg::DIVD_W-1:0] rem_q, dvs_q, rem1, rem2;
  logic [gdr_pkg::DIVN_W-1:0] quo_q, quo1, quo2;
  logic [gdr_pkg::ITER_W-1:0] cnt_q;
  logic                       run_q, done_q;
  logic [gdr_pkg::DIVD_W:0]   r1, r2;
  logic                       ge1, ge2;

  always_comb begin
    r1   = {rem_q, quo_q[gdr_pkg::DIVN_W-1]};
    ge1  = r1 >= {1'b0, dvs_q};
    rem1 = ge1 ? gdr_pkg::DIVD_W'(r1 - {1'b0, dvs_q}) : gdr_pkg::DIVD_W'(r1);
    quo1 = {quo_q[gdr_pkg::DIVN_W-2:0], ge1};
    r2   = {rem1, quo1[gdr_pkg::DIVN_W-1]};
    ge2  = r2 >= {1'b0, dvs_q};
    rem2 = ge2 ? gdr_pkg::DIVD_W'(r2 - {1'b0, dvs_q}) : gdr_pkg::DIVD_W'(r2);
    quo2 = {quo1[gdr_pkg::DIVN_W-2:0], ge2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= gdr_pkg::ITER_W'(gdr_pkg::DIV_ITER);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == gdr_pkg::ITER_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem2;
      quo_q <= quo2;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> src/gdr_datapath.sv
// ----------------------------------------------------------------------------
// gdr_datapath
// Map store, ray set-up, DDA walk, distance, stripe and texture arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module gdr_datapath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire gdr_pkg::cmd_t              cmd_i,
  output gdr_pkg::stat_t                  stat_o,
  input  wire gdr_pkg::cfg_t              cfg_i,
  input  wire logic [gdr_pkg::COL_W-1:0]  column_i,
  input  wire logic [gdr_pkg::CELL_W-1:0] cell_x_i,
  input  wire logic [gdr_pkg::CELL_W-1:0] cell_y_i,
  input  wire logic [gdr_pkg::CODE_W-1:0] cell_value_i,
  input  wire logic                       out_stall_i,
  output logic                            out_valid_o,
  output logic [gdr_pkg::COL_W-1:0]       col_out_o,
  output logic                            hit_found_o,
  output logic                            hit_side_o,
  output logic [gdr_pkg::PERP_W-1:0]      perp_dist_o,
  output logic [gdr_pkg::LH_W-1:0]        line_height_o,
  output logic [gdr_pkg::COL_W-1:0]       draw_start_o,
  output logic [gdr_pkg::COL_W-1:0]       draw_end_o,
  output logic [gdr_pkg::CODE_W-1:0]      tex_index_o,
  output logic [5:0]                      tex_col_o,
  output logic [gdr_pkg::FRAC_W-1:0]      wall_frac_o,
  output logic [gdr_pkg::CELL_W-1:0]      hit_cell_x_o,
  output logic [gdr_pkg::CELL_W-1:0]      hit_cell_y_o
);

  localparam int DELTA_SH = gdr_pkg::DELTA_W - 1 - 16;

  logic [gdr_pkg::CODE_W-1:0] map_mem [gdr_pkg::MAP_CELLS];

  logic [gdr_pkg::COL_W-1:0]    col_q;
  logic [gdr_pkg::CAM_W-1:0]    camx_q;
  logic [gdr_pkg::R_W-1:0]      rx_q, ry_q;
  logic [gdr_pkg::DELTA_W-1:0]  dx_q, dy_q;
  logic signed [gdr_pkg::PROD_W-1:0] prod_q;
  logic [gdr_pkg::SD_W-1:0]     sdx_q, sdy_q;
  logic [gdr_pkg::M_W-1:0]      mx_q, my_q;
  logic [gdr_pkg::STEP_W-1:0]   n_q;
  logic                         side_q, hit_q, out_valid_q;
  logic [gdr_pkg::CODE_W-1:0]   code_q, rdata_q;
  logic [gdr_pkg::PERP_W-1:0]   perp_q;
  logic [gdr_pkg::LH_W-1:0]     lh_q;

  logic [gdr_pkg::SCR_W-1:0]    width_eff, hgt_eff;
  logic                         rx_neg, ry_neg, rx_zero, ry_zero;
  logic [gdr_pkg::DIVD_W-1:0]   rx_mag, ry_mag;
  logic [16:0]                  fxp, fyp;
  logic [gdr_pkg::DIVN_W-1:0]   dvd, quo;
  logic [gdr_pkg::DIVD_W-1:0]   dvs;
  logic                         div_done;
  logic signed [gdr_pkg::MUL_A_W-1:0] mul_a;
  logic signed [gdr_pkg::MUL_B_W-1:0] mul_b;

  logic                         step_x;
  logic [gdr_pkg::M_W-1:0]      mx_nx, my_nx, nx, ny;
  logic                         oob;
  logic [gdr_pkg::ADDR_W-1:0]   raddr, waddr;
  logic                         wr_ok;

  logic [gdr_pkg::M_W-1:0]      m_sel;
  logic [gdr_pkg::POS_W-1:0]    p_sel;
  logic                         rd_neg, rd_zero;
  logic [gdr_pkg::DIVD_W-1:0]   rd_mag;
  logic [gdr_pkg::NUM_W-1:0]    num_u, num_mag;
  logic                         num_neg;

  logic [gdr_pkg::R_W-1:0]      along;
  logic [gdr_pkg::POS_W-1:0]    base;
  logic [gdr_pkg::FRAC_W-1:0]   frac;
  logic [24:0]                  tc_full;
  logic [gdr_pkg::TC_W-1:0]     tc, tcm;
  logic                         mirror;
  logic [16:0]                  half_h, half_l, ds_s, de_u, de_c;

  assign width_eff = (cfg_i.screen_width == '0) ? gdr_pkg::SCR_W'(1) : cfg_i.screen_width;
  assign hgt_eff   = (cfg_i.screen_height == '0) ? gdr_pkg::SCR_W'(1) : cfg_i.screen_height;

  assign rx_neg  = rx_q[gdr_pkg::R_W-1];
  assign ry_neg  = ry_q[gdr_pkg::R_W-1];
  assign rx_zero = (rx_q == '0);
  assign ry_zero = (ry_q == '0);
  assign rx_mag  = gdr_pkg::DIVD_W'(rx_neg ? -rx_q : rx_q);
  assign ry_mag  = gdr_pkg::DIVD_W'(ry_neg ? -ry_q : ry_q);
  assign fxp = rx_neg ? {1'b0, cfg_i.pos_x[15:0]} : 17'h10000 - {1'b0, cfg_i.pos_x[15:0]};
  assign fyp = ry_neg ? {1'b0, cfg_i.pos_y[15:0]} : 17'h10000 - {1'b0, cfg_i.pos_y[15:0]};

  // boundary offset and ray component of the crossed side
  always_comb begin
    m_sel   = side_q ? my_q : mx_q;
    p_sel   = side_q ? cfg_i.pos_y : cfg_i.pos_x;
    rd_neg  = side_q ? ry_neg : rx_neg;
    rd_zero = side_q ? ry_zero : rx_zero;
    rd_mag  = side_q ? ry_mag : rx_mag;
    num_u   = gdr_pkg::NUM_W'({m_sel[gdr_pkg::MAP_BITS-1:0], 16'h0000})
            - gdr_pkg::NUM_W'(p_sel)
            + (rd_neg ? gdr_pkg::NUM_W'(24'h010000) : gdr_pkg::NUM_W'(0));
    num_neg = num_u[gdr_pkg::NUM_W-1];
    num_mag = num_neg ? -num_u : num_u;
  end

  always_comb begin
    dvd = '0;
    dvs = '0;
    case (cmd_i.div_sel)
      gdr_pkg::DIV_CAM: begin
        dvd = gdr_pkg::DIVN_W'({col_q, 17'h00000});
        dvs = gdr_pkg::DIVD_W'(width_eff);
      end
      gdr_pkg::DIV_DX: begin
        dvd = gdr_pkg::DIVN_W'(1) << 32;
        dvs = rx_mag;
      end
      gdr_pkg::DIV_DY: begin
        dvd = gdr_pkg::DIVN_W'(1) << 32;
        dvs = ry_mag;
      end
      gdr_pkg::DIV_PERP: begin
        dvd = gdr_pkg::DIVN_W'({num_mag, 16'h0000});
        dvs = rd_mag;
      end
      gdr_pkg::DIV_LH: begin
        dvd = gdr_pkg::DIVN_W'({hgt_eff, 16'h0000});
        dvs = gdr_pkg::DIVD_W'(perp_q);
      end
      default: begin
        dvd = '0;
        dvs = '0;
      end
    endcase
  end

  gdr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      gdr_pkg::MUL_RX: begin
        mul_a = {{(gdr_pkg::MUL_A_W-gdr_pkg::CAM_W){camx_q[gdr_pkg::CAM_W-1]}}, camx_q};
        mul_b = {{(gdr_pkg::MUL_B_W-gdr_pkg::PLANE_W){cfg_i.plane_x[gdr_pkg::PLANE_W-1]}},
                 cfg_i.plane_x};
      end
      gdr_pkg::MUL_RY: begin
        mul_a = {{(gdr_pkg::MUL_A_W-gdr_pkg::CAM_W){camx_q[gdr_pkg::CAM_W-1]}}, camx_q};
        mul_b = {{(gdr_pkg::MUL_B_W-gdr_pkg::PLANE_W){cfg_i.plane_y[gdr_pkg::PLANE_W-1]}},
                 cfg_i.plane_y};
      end
      gdr_pkg::MUL_SDX: begin
        mul_a = {1'b0, dx_q[32:0]};
        mul_b = gdr_pkg::MUL_B_W'(fxp);
      end
      gdr_pkg::MUL_SDY: begin
        mul_a = {1'b0, dy_q[32:0]};
        mul_b = gdr_pkg::MUL_B_W'(fyp);
      end
      gdr_pkg::MUL_FRAC: begin
        mul_a = {along[gdr_pkg::R_W-1], along};
        mul_b = gdr_pkg::MUL_B_W'(perp_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // grid step
  always_comb begin
    step_x = sdx_q < sdy_q;
    mx_nx  = rx_neg ? mx_q - 1'b1 : mx_q + 1'b1;
    my_nx  = ry_neg ? my_q - 1'b1 : my_q + 1'b1;
    nx     = step_x ? mx_nx : mx_q;
    ny     = step_x ? my_q : my_nx;
    oob    = nx[gdr_pkg::M_W-1] || ny[gdr_pkg::M_W-1]
          || (nx >= gdr_pkg::M_W'(gdr_pkg::MAP_SIZE))
          || (ny >= gdr_pkg::M_W'(gdr_pkg::MAP_SIZE));
    raddr  = gdr_pkg::ADDR_W'(ny[gdr_pkg::MAP_BITS-1:0]) * gdr_pkg::ADDR_W'(gdr_pkg::MAP_SIZE)
           + gdr_pkg::ADDR_W'(nx[gdr_pkg::MAP_BITS-1:0]);
    waddr  = gdr_pkg::ADDR_W'(cell_y_i) * gdr_pkg::ADDR_W'(gdr_pkg::MAP_SIZE)
           + gdr_pkg::ADDR_W'(cell_x_i);
    wr_ok  = (32'(cell_x_i) < gdr_pkg::MAP_SIZE) && (32'(cell_y_i) < gdr_pkg::MAP_SIZE);
  end

  // texture and stripe
  always_comb begin
    along   = side_q ? rx_q : ry_q;
    base    = side_q ? cfg_i.pos_x : cfg_i.pos_y;
    frac    = base[15:0] + prod_q[31:16];
    tc_full = 25'(frac) * 25'(gdr_pkg::TEX_SIZE);
    tc      = tc_full[24:16];
    mirror  = (!side_q && !rx_neg && !rx_zero) || (side_q && ry_neg);
    tcm     = mirror ? gdr_pkg::TC_W'(gdr_pkg::TEX_SIZE - 1) - tc : tc;
    half_h  = 17'(hgt_eff >> 1);
    half_l  = 17'(lh_q >> 1);
    ds_s    = half_h - half_l;
    de_u    = half_h + half_l;
    de_c    = (de_u >= 17'(hgt_eff)) ? 17'(hgt_eff) - 17'd1 : de_u;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.map_write && wr_ok) begin
      map_mem[waddr] <= cell_value_i;
    end
    if (cmd_i.step) begin
      rdata_q <= map_mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      n_q         <= '0;
    end else begin
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.cast_start) begin
        hit_q <= 1'b0;
      end else if (cmd_i.look && (rdata_q != '0)) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.dda_init) begin
        n_q <= '0;
      end else if (cmd_i.step) begin
        n_q <= n_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cast_start) begin
      col_q <= column_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.div_take && div_done) begin
      case (cmd_i.div_sel)
        gdr_pkg::DIV_CAM: camx_q <= gdr_pkg::CAM_W'(quo) - gdr_pkg::CAM_W'(65536);
        gdr_pkg::DIV_DX:  dx_q <= rx_zero ? gdr_pkg::DELTA_W'(1) << (gdr_pkg::DELTA_W - 1)
                                          : gdr_pkg::DELTA_W'(quo);
        gdr_pkg::DIV_DY:  dy_q <= ry_zero ? gdr_pkg::DELTA_W'(1) << (gdr_pkg::DELTA_W - 1)
                                          : gdr_pkg::DELTA_W'(quo);
        gdr_pkg::DIV_PERP: begin
          if (rd_zero) begin
            perp_q <= gdr_pkg::PERP_MAX;
          end else if ((num_u != '0) && (num_neg != rd_neg)) begin
            perp_q <= '0;
          end else if (quo[gdr_pkg::DIVN_W-1:gdr_pkg::PERP_W] != '0) begin
            perp_q <= gdr_pkg::PERP_MAX;
          end else begin
            perp_q <= quo[gdr_pkg::PERP_W-1:0];
          end
        end
        gdr_pkg::DIV_LH: begin
          if ((perp_q == '0) || (quo[gdr_pkg::DIVN_W-1:gdr_pkg::LH_W] != '0)) begin
            lh_q <= gdr_pkg::LH_MAX;
          end else begin
            lh_q <= quo[gdr_pkg::LH_W-1:0];
          end
        end
        default: begin
          lh_q <= lh_q;
        end
      endcase
    end
    if (cmd_i.rx_load) begin
      rx_q <= {{(gdr_pkg::R_W-gdr_pkg::DIR_W){cfg_i.dir_x[gdr_pkg::DIR_W-1]}}, cfg_i.dir_x}
            + prod_q[gdr_pkg::R_W+15:16];
    end
    if (cmd_i.ry_load) begin
      ry_q <= {{(gdr_pkg::R_W-gdr_pkg::DIR_W){cfg_i.dir_y[gdr_pkg::DIR_W-1]}}, cfg_i.dir_y}
            + prod_q[gdr_pkg::R_W+15:16];
    end
    if (cmd_i.sdx_load) begin
      sdx_q <= rx_zero ? gdr_pkg::SD_W'(fxp) << DELTA_SH : gdr_pkg::SD_W'(prod_q[49:16]);
    end
    if (cmd_i.dda_init) begin
      sdy_q <= ry_zero ? gdr_pkg::SD_W'(fyp) << DELTA_SH : gdr_pkg::SD_W'(prod_q[49:16]);
      mx_q  <= gdr_pkg::M_W'(cfg_i.pos_x[gdr_pkg::POS_W-1:16]);
      my_q  <= gdr_pkg::M_W'(cfg_i.pos_y[gdr_pkg::POS_W-1:16]);
    end else if (cmd_i.step) begin
      if (step_x) begin
        sdx_q  <= sdx_q + gdr_pkg::SD_W'(dx_q);
        mx_q   <= mx_nx;
        side_q <= 1'b0;
      end else begin
        sdy_q  <= sdy_q + gdr_pkg::SD_W'(dy_q);
        my_q   <= my_nx;
        side_q <= 1'b1;
      end
    end
    if (cmd_i.look) begin
      code_q <= rdata_q;
    end
    if (cmd_i.out_load) begin
      col_out_o <= col_q;
      if (hit_q) begin
        hit_found_o   <= 1'b1;
        hit_side_o    <= side_q;
        perp_dist_o   <= perp_q;
        line_height_o <= lh_q;
        draw_start_o  <= ds_s[16] ? '0 : ds_s[gdr_pkg::COL_W-1:0];
        draw_end_o    <= de_c[gdr_pkg::COL_W-1:0];
        tex_index_o   <= code_q - 1'b1;
        tex_col_o     <= tcm[5:0];
        wall_frac_o   <= frac;
        hit_cell_x_o  <= mx_q[gdr_pkg::CELL_W-1:0];
        hit_cell_y_o  <= my_q[gdr_pkg::CELL_W-1:0];
      end else begin
        hit_found_o   <= 1'b0;
        hit_side_o    <= 1'b0;
        perp_dist_o   <= '0;
        line_height_o <= '0;
        draw_start_o  <= '0;
        draw_end_o    <= '0;
        tex_index_o   <= '0;
        tex_col_o     <= '0;
        wall_frac_o   <= '0;
        hit_cell_x_o  <= '0;
        hit_cell_y_o  <= '0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign stat_o.div_done   = div_done;
  assign stat_o.steps_done = (n_q == gdr_pkg::STEP_W'(gdr_pkg::MAX_STEPS));
  assign stat_o.next_oob   = oob;
  assign stat_o.cell_hit   = (rdata_q != '0);
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

>>> src/gdr_ctrl.sv
// ----------------------------------------------------------------------------
// gdr_ctrl
// Sequencer for map writes and ray casts.
// ----------------------------------------------------------------------------
`default_nettype none

module gdr_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           req_type_i,
  output logic                in_stall_o,
  input  wire gdr_pkg::stat_t stat_i,
  output gdr_pkg::cmd_t       cmd_o
);

  typedef enum logic [20:0] {
    S_IDLE      = 21'h000001,
    S_CAM_GO    = 21'h000002,
    S_CAM_WAIT  = 21'h000004,
    S_RX_MUL    = 21'h000008,
    S_RY_MUL    = 21'h000010,
    S_RY_SUM    = 21'h000020,
    S_DX_GO     = 21'h000040,
    S_DX_WAIT   = 21'h000080,
    S_DY_GO     = 21'h000100,
    S_DY_WAIT   = 21'h000200,
    S_SDX_MUL   = 21'h000400,
    S_SDY_MUL   = 21'h000800,
    S_SD_SET    = 21'h001000,
    S_STEP      = 21'h002000,
    S_LOOK      = 21'h004000,
    S_PERP_GO   = 21'h008000,
    S_PERP_WAIT = 21'h010000,
    S_LH_GO     = 21'h020000,
    S_LH_WAIT   = 21'h040000,
    S_FRAC_MUL  = 21'h080000,
    S_FIN       = 21'h100000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i) begin
            cmd_o.cast_start = 1'b1;
            state_d = S_CAM_GO;
          end else begin
            cmd_o.map_write = 1'b1;
          end
        end
      end
      S_CAM_GO: begin
        cmd_o.div_sel   = gdr_pkg::DIV_CAM;
        cmd_o.div_start = 1'b1;
        state_d = S_CAM_WAIT;
      end
      S_CAM_WAIT: begin
        cmd_o.div_sel  = gdr_pkg::DIV_CAM;
        cmd_o.div_take = 1'b1;
        if (stat_i.div_done) state_d = S_RX_MUL;
      end
      S_RX_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = gdr_pkg::MUL_RX;
        state_d = S_RY_MUL;
      end
      S_RY_MUL: begin
        cmd_o.rx_load = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = gdr_pkg::MUL_RY;
        state_d = S_RY_SUM;
      end
      S_RY_SUM: begin
        cmd_o.ry_load = 1'b1;
        state_d = S_DX_GO;
      end
      S_DX_GO: begin
        cmd_o.div_sel   = gdr_pkg::DIV_DX;
        cmd_o.div_start = 1'b1;
        state_d = S_DX_WAIT;
      end
      S_DX_WAIT: begin
        cmd_o.div_sel  = gdr_pkg::DIV_DX;
        cmd_o.div_take = 1'b1;
        if (stat_i.div_done) state_d = S_DY_GO;
      end
      S_DY_GO: begin
        cmd_o.div_sel   = gdr_pkg::DIV_DY;
        cmd_o.div_start = 1'b1;
        state_d = S_DY_WAIT;
      end
      S_DY_WAIT: begin
        cmd_o.div_sel  = gdr_pkg::DIV_DY;
        cmd_o.div_take = 1'b1;
        if (stat_i.div_done) state_d = S_SDX_MUL;
      end
      S_SDX_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = gdr_pkg::MUL_SDX;
        state_d = S_SDY_MUL;
      end
      S_SDY_MUL: begin
        cmd_o.sdx_load = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = gdr_pkg::MUL_SDY;
        state_d = S_SD_SET;
      end
      S_SD_SET: begin
        cmd_o.dda_init = 1'b1;
        state_d = S_STEP;
      end
      S_STEP: begin
        if (stat_i.steps_done) begin
          state_d = S_FIN;
        end else begin
          cmd_o.step = 1'b1;
          state_d = stat_i.next_oob ? S_FIN : S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.look = 1'b1;
        state_d = stat_i.cell_hit ? S_PERP_GO : S_STEP;
      end
      S_PERP_GO: begin
        cmd_o.div_sel   = gdr_pkg::DIV_PERP;
        cmd_o.div_start = 1'b1;
        state_d = S_PERP_WAIT;
      end
      S_PERP_WAIT: begin
        cmd_o.div_sel  = gdr_pkg::DIV_PERP;
        cmd_o.div_take = 1'b1;
        if (stat_i.div_done) state_d = S_LH_GO;
      end
      S_LH_GO: begin
        cmd_o.div_sel   = gdr_pkg::DIV_LH;
        cmd_o.div_start = 1'b1;
        state_d = S_LH_WAIT;
      end
      S_LH_WAIT: begin
        cmd_o.div_sel  = gdr_pkg::DIV_LH;
        cmd_o.div_take = 1'b1;
        if (stat_i.div_done) state_d = S_FRAC_MUL;
      end
      S_FRAC_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = gdr_pkg::MUL_FRAC;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> src/grid_dda_ray_wall_cast.sv
// ----------------------------------------------------------------------------
// grid_dda_ray_wall_cast
// Grid DDA wall ray caster: map load and per-column cast, one item at a time.
// ----------------------------------------------------------------------------
// A map-write item is taken while idle and gives no result. A cast item
// that hits a wall runs five divisions through one shared divider at two
// quotient bits a cycle, and each of the grid steps walked (at most
// MAX_STEPS) goes through a step state and a look state for the registered
// map read. A cast that leaves the map or runs out of steps skips the
// distance and height divisions. The next item is taken once the cast has
// moved its result into the output register.
`default_nettype none

`include "assert_macros.svh"

module grid_dda_ray_wall_cast (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          req_type_i,
  input  wire logic [gdr_pkg::COL_W-1:0]     column_i,
  input  wire logic [gdr_pkg::CELL_W-1:0]    cell_x_i,
  input  wire logic [gdr_pkg::CELL_W-1:0]    cell_y_i,
  input  wire logic [gdr_pkg::CODE_W-1:0]    cell_value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [gdr_pkg::COL_W-1:0]          col_out_o,
  output logic                               hit_found_o,
  output logic                               hit_side_o,
  output logic [gdr_pkg::PERP_W-1:0]         perp_dist_o,
  output logic [gdr_pkg::LH_W-1:0]           line_height_o,
  output logic [gdr_pkg::COL_W-1:0]          draw_start_o,
  output logic [gdr_pkg::COL_W-1:0]          draw_end_o,
  output logic [gdr_pkg::CODE_W-1:0]         tex_index_o,
  output logic [5:0]                         tex_col_o,
  output logic [gdr_pkg::FRAC_W-1:0]         wall_frac_o,
  output logic [gdr_pkg::CELL_W-1:0]         hit_cell_x_o,
  output logic [gdr_pkg::CELL_W-1:0]         hit_cell_y_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [gdr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [gdr_pkg::CFG_DAT_W-1:0] cfg_data_i
);

  gdr_pkg::cfg_t  cfg_q;
  gdr_pkg::cmd_t  cmd;
  gdr_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width  <= gdr_pkg::RST_WIDTH;
      cfg_q.screen_height <= gdr_pkg::RST_HEIGHT;
      cfg_q.pos_x         <= gdr_pkg::RST_POS_X;
      cfg_q.pos_y         <= gdr_pkg::RST_POS_Y;
      cfg_q.dir_x         <= gdr_pkg::RST_DIR_X;
      cfg_q.dir_y         <= gdr_pkg::RST_DIR_Y;
      cfg_q.plane_x       <= gdr_pkg::RST_PLANE_X;
      cfg_q.plane_y       <= gdr_pkg::RST_PLANE_Y;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (gdr_pkg::cfg_idx_e'(cfg_index_i))
        gdr_pkg::CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data_i[gdr_pkg::SCR_W-1:0];
        gdr_pkg::CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data_i[gdr_pkg::SCR_W-1:0];
        gdr_pkg::CFG_VIEW_POS_X:    cfg_q.pos_x         <= cfg_data_i[gdr_pkg::POS_W-1:0];
        gdr_pkg::CFG_VIEW_POS_Y:    cfg_q.pos_y         <= cfg_data_i[gdr_pkg::POS_W-1:0];
        gdr_pkg::CFG_VIEW_DIR_X:    cfg_q.dir_x         <= cfg_data_i[gdr_pkg::DIR_W-1:0];
        gdr_pkg::CFG_VIEW_DIR_Y:    cfg_q.dir_y         <= cfg_data_i[gdr_pkg::DIR_W-1:0];
        gdr_pkg::CFG_CAM_PLANE_X:   cfg_q.plane_x       <= cfg_data_i[gdr_pkg::PLANE_W-1:0];
        gdr_pkg::CFG_CAM_PLANE_Y:   cfg_q.plane_y       <= cfg_data_i[gdr_pkg::PLANE_W-1:0];
        default:                    cfg_q               <= cfg_q;
      endcase
    end
  end

  gdr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gdr_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_i         (cfg_q),
    .column_i      (column_i),
    .cell_x_i      (cell_x_i),
    .cell_y_i      (cell_y_i),
    .cell_value_i  (cell_value_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .col_out_o     (col_out_o),
    .hit_found_o   (hit_found_o),
    .hit_side_o    (hit_side_o),
    .perp_dist_o   (perp_dist_o),
    .line_height_o (line_height_o),
    .draw_start_o  (draw_start_o),
    .draw_end_o    (draw_end_o),
    .tex_index_o   (tex_index_o),
    .tex_col_o     (tex_col_o),
    .wall_frac_o   (wall_frac_o),
    .hit_cell_x_o  (hit_cell_x_o),
    .hit_cell_y_o  (hit_cell_y_o)
  );

  `GDR_ASSERT_SAME(a_load_free, cmd.out_load, stat.out_free, "result loaded over a held one")
  `GDR_ASSERT_NEXT(a_div_multi, cmd.div_start, !stat.div_done, "divider finished too early")
  `GDR_ASSERT_SAME(a_look_after_step, cmd.look, $past(cmd.step), "map lookup without a step")

endmodule

`default_nettype wire
